@@ rtl/core/rfc_pkg.sv @@
// Package for the receive frame classifier.
// Holds widths, verdict and register codes and the types shared by the
// collect, classify and top-level modules. No dependencies.
package rfc_pkg;

  // Frame size limit and derived byte counter width
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

  // Header bytes kept per frame
  localparam int HDR_BYTES = 42;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);

  // Field widths
  localparam int FRAME_LEN_W = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int OUT_DATA_W  = 40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_SLOT0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_SLOT1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_SLOT2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_SLOT3 = 3'd5;

  // Verdict codes
  localparam logic [3:0] V_NOT_ADDRESSED = 4'd0;
  localparam logic [3:0] V_BAD_ETHERTYPE = 4'd1;
  localparam logic [3:0] V_NOT_IPV4      = 4'd2;
  localparam logic [3:0] V_IP_NOT_OURS   = 4'd3;
  localparam logic [3:0] V_OTHER_PROTO   = 4'd4;
  localparam logic [3:0] V_UDP_LEN_BAD   = 4'd5;
  localparam logic [3:0] V_PORT_UNMATCH  = 4'd6;
  localparam logic [3:0] V_UDP_ACCEPTED  = 4'd7;
  localparam logic [3:0] V_ICMP_NOT_ECHO = 4'd8;
  localparam logic [3:0] V_ECHO_REQUEST  = 4'd9;
  localparam logic [3:0] V_ARP_BAD_TYPE  = 4'd10;
  localparam logic [3:0] V_ARP_REQ_OTHER = 4'd11;
  localparam logic [3:0] V_ARP_REQ_OURS  = 4'd12;
  localparam logic [3:0] V_ARP_REPLY     = 4'd13;
  localparam logic [3:0] V_ARP_OTHER_OP  = 4'd14;
  localparam logic [3:0] V_RUNT          = 4'd15;

  // Address kinds
  localparam logic [1:0] AK_NONE      = 2'd0;
  localparam logic [1:0] AK_UNICAST   = 2'd1;
  localparam logic [1:0] AK_MULTICAST = 2'd2;
  localparam logic [1:0] AK_BROADCAST = 2'd3;

  // Protocol constants
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETYPE_ARP    = 16'h0806;
  localparam logic [7:0]  PROTO_UDP    = 8'h11;
  localparam logic [7:0]  PROTO_ICMP   = 8'h01;
  localparam logic [7:0]  ICMP_ECHO    = 8'h08;
  localparam logic [15:0] ARP_HTYPE    = 16'h0001;
  localparam logic [15:0] ARP_OP_REQ   = 16'h0001;
  localparam logic [15:0] ARP_OP_REPLY = 16'h0002;
  localparam logic [15:0] UDP_HDR_LEN  = 16'd8;

  // Header bytes, byte i at index i
  typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

  // Finished-frame status from the collector
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] n;
  } frame_info_t;

  // One classification result
  typedef struct packed {
    logic [FRAME_LEN_W-1:0] frame_length;
    logic [15:0]            udp_payload_length;
    logic [1:0]             port_slot;
    logic [1:0]             address_kind;
    logic                   accepted;
    logic [3:0]             verdict;
  } result_t;

endpackage

@@ rtl/core/rx_frame_classifier.sv @@
// Receive frame classifier top level: config registers, collector,
// classifier and the registered result stage. Depends on rfc_pkg,
// rfc_collect and rfc_classify.
// The result register takes the frame after the collector flags it done.
// Throughput: one byte per cycle; in_tready drops only while a finished
// frame waits behind a result that out_tready has not taken.
// Reset (rst_n, synchronous): clears config, byte count and valid flags;
// header bytes are not cleared.
module rx_frame_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // frame_byte
  input  logic                              in_tlast,   // last_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // verdict[3:0], accepted[4], address_kind[6:5], port_slot[8:7],
  // udp_payload_length[24:9], frame_length[36:25], zero pad[39:37]
  output logic [rfc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rfc_pkg::*;

  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic [15:0] port_slot0_r;
  logic [15:0] port_slot1_r;
  logic [15:0] port_slot2_r;
  logic [15:0] port_slot3_r;

  logic        byte_accept;
  logic        advance;
  hdr_t        hdr;
  frame_info_t info;
  result_t     res;
  result_t     result_r;
  logic        out_valid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r    <= '0;
      own_ip_r     <= '0;
      port_slot0_r <= '0;
      port_slot1_r <= '0;
      port_slot2_r <= '0;
      port_slot3_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OWN_MAC:    own_mac_r    <= cfg_wdata[47:0];
        REG_OWN_IP:     own_ip_r     <= cfg_wdata[31:0];
        REG_PORT_SLOT0: port_slot0_r <= cfg_wdata[15:0];
        REG_PORT_SLOT1: port_slot1_r <= cfg_wdata[15:0];
        REG_PORT_SLOT2: port_slot2_r <= cfg_wdata[15:0];
        REG_PORT_SLOT3: port_slot3_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Handshake: the finished frame moves on when the result slot frees up
  assign advance     = !out_valid_r || out_tready;
  assign in_tready   = !info.done || advance;
  assign byte_accept = in_tvalid && in_tready;

  rfc_collect u_collect (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .frame_byte  (in_tdata),
    .last_byte   (in_tlast),
    .advance     (advance),
    .hdr         (hdr),
    .info        (info)
  );

  rfc_classify u_classify (
    .hdr        (hdr),
    .n          (info.n),
    .own_mac    (own_mac_r),
    .own_ip     (own_ip_r),
    .port_slot0 (port_slot0_r),
    .port_slot1 (port_slot1_r),
    .port_slot2 (port_slot2_r),
    .port_slot3 (port_slot3_r),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= info.done;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && info.done) result_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), result_r};

endmodule

@@ rtl/core/rfc_collect.sv @@
// Byte collector: keeps the first header bytes of a frame and counts bytes.
// Flags a finished frame until the classifier result stage takes it.
// Depends on rfc_pkg.
module rfc_collect (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_accept,
  input  logic [7:0]            frame_byte,
  input  logic                  last_byte,
  input  logic                  advance,
  output rfc_pkg::hdr_t         hdr,
  output rfc_pkg::frame_info_t  info
);
  import rfc_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] n_r;
  logic             done_r;
  hdr_t             hdr_r;

  // Saturating count including the byte being taken
  assign count_inc = (count_r < CNT_W'(MAX_FRAME_BYTES)) ? count_r + 1'b1 : count_r;

  // Counter and frame-done flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      if (byte_accept && last_byte) begin
        count_r <= '0;
        done_r  <= 1'b1;
      end else begin
        if (byte_accept) count_r <= count_inc;
        if (advance) done_r <= 1'b0;
      end
    end
  end

  // Frame length of the finished frame
  always_ff @(posedge clk) begin
    if (byte_accept && last_byte) n_r <= count_inc;
  end

  // Header store, written at the current byte position
  always_ff @(posedge clk) begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (byte_accept && count_r == CNT_W'(i)) hdr_r[i] <= frame_byte;
    end
  end

  assign hdr       = hdr_r;
  assign info.done = done_r;
  assign info.n    = n_r;

endmodule

@@ rtl/core/rfc_classify.sv @@
// Frame classifier logic: MAC filter, ethertype, IPv4/UDP/ICMP and ARP checks.
// Pure combinational decision over the stored header and frame length.
// Depends on rfc_pkg.
module rfc_classify (
  input  rfc_pkg::hdr_t            hdr,
  input  logic [rfc_pkg::CNT_W-1:0] n,
  input  logic [47:0]               own_mac,
  input  logic [31:0]               own_ip,
  input  logic [15:0]               port_slot0,
  input  logic [15:0]               port_slot1,
  input  logic [15:0]               port_slot2,
  input  logic [15:0]               port_slot3,
  output rfc_pkg::result_t          res
);
  import rfc_pkg::*;

  logic [47:0] dst_mac;
  logic        uc;
  logic        bc;
  logic        mc;
  logic [1:0]  kind;
  logic [15:0] etype;
  logic [15:0] udp_port;
  logic [15:0] plen;
  logic [16:0] room;
  logic [15:0] arp_op;
  logic [3:0]  v;
  logic [1:0]  slot;

  // Header fields
  assign dst_mac  = {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5]};
  assign etype    = {hdr[12], hdr[13]};
  assign udp_port = {hdr[36], hdr[37]};
  assign plen     = {hdr[38], hdr[39]} - UDP_HDR_LEN;
  assign room     = 17'(n - CNT_W'(HDR_BYTES));
  assign arp_op   = {hdr[20], hdr[21]};

  // Destination address kind, own unicast first
  assign uc = (dst_mac == own_mac);
  assign bc = (dst_mac == 48'hffff_ffff_ffff);
  assign mc = (hdr[0] == 8'h01) && (hdr[1] == 8'h00) && (hdr[2] == 8'h5e);

  always_comb begin
    kind = AK_NONE;
    if (n >= CNT_W'(6)) begin
      priority if (uc) kind = AK_UNICAST;
      else if (bc)     kind = AK_BROADCAST;
      else if (mc)     kind = AK_MULTICAST;
      else             kind = AK_NONE;
    end
  end

  // Verdict; runt unless a decision is reached with enough bytes
  always_comb begin
    v    = V_RUNT;
    slot = 2'd0;
    if (n >= CNT_W'(6)) begin
      if (kind == AK_NONE) begin
        v = V_NOT_ADDRESSED;
      end else if (n >= CNT_W'(14)) begin
        if (etype == ETYPE_IPV4) begin
          if (n >= CNT_W'(15)) begin
            if (hdr[14][7:4] != 4'd4) begin
              v = V_NOT_IPV4;
            end else if (hdr[0] == own_mac[47:40] && n < CNT_W'(34)) begin
              v = V_RUNT;
            end else if (hdr[0] == own_mac[47:40] &&
                         {hdr[30], hdr[31], hdr[32], hdr[33]} != own_ip) begin
              v = V_IP_NOT_OURS;
            end else if (n >= CNT_W'(24)) begin
              if (hdr[23] == PROTO_UDP) begin
                if (n >= CNT_W'(HDR_BYTES)) begin
                  if (17'(plen) > room) begin
                    v = V_UDP_LEN_BAD;
                  end else begin
                    v = V_UDP_ACCEPTED;
                    priority if (udp_port == port_slot0) slot = 2'd0;
                    else if (udp_port == port_slot1)     slot = 2'd1;
                    else if (udp_port == port_slot2)     slot = 2'd2;
                    else if (udp_port == port_slot3)     slot = 2'd3;
                    else                                 v = V_PORT_UNMATCH;
                  end
                end
              end else if (hdr[23] == PROTO_ICMP) begin
                if (n >= CNT_W'(35)) begin
                  v = (hdr[34] == ICMP_ECHO) ? V_ECHO_REQUEST : V_ICMP_NOT_ECHO;
                end
              end else begin
                v = V_OTHER_PROTO;
              end
            end
          end
        end else if (etype == ETYPE_ARP) begin
          if (n >= CNT_W'(18)) begin
            if ({hdr[14], hdr[15]} != ARP_HTYPE || {hdr[16], hdr[17]} != ETYPE_IPV4) begin
              v = V_ARP_BAD_TYPE;
            end else if (n >= CNT_W'(22)) begin
              if (arp_op == ARP_OP_REQ) begin
                if (n >= CNT_W'(HDR_BYTES)) begin
                  v = ({hdr[38], hdr[39], hdr[40], hdr[41]} == own_ip) ?
                      V_ARP_REQ_OURS : V_ARP_REQ_OTHER;
                end
              end else if (arp_op == ARP_OP_REPLY) begin
                v = V_ARP_REPLY;
              end else begin
                v = V_ARP_OTHER_OP;
              end
            end
          end
        end else begin
          v = V_BAD_ETHERTYPE;
        end
      end
    end
  end

  // Result fields
  always_comb begin
    res.verdict            = v;
    res.accepted           = (v == V_UDP_ACCEPTED) || (v == V_ECHO_REQUEST) ||
                             (v == V_ARP_REQ_OURS) || (v == V_ARP_REPLY);
    res.address_kind       = kind;
    res.port_slot          = (v == V_UDP_ACCEPTED) ? slot : 2'd0;
    res.udp_payload_length = (v == V_UDP_LEN_BAD || v == V_PORT_UNMATCH ||
                              v == V_UDP_ACCEPTED) ? plen : 16'd0;
    res.frame_length       = FRAME_LEN_W'(n);
  end

endmodule
